FILE: rtl/stsm_pkg.sv
// Shared types and constants for the segment tree sum/min block.
// No dependencies; used by every module under rtl/.
`default_nettype none
package stsm_pkg;

   localparam int LEAF_BITS  = 10;
   localparam int ADDR_BITS  = LEAF_BITS + 1;           // heap node address
   localparam int POS_BITS   = LEAF_BITS + 2;           // half-open range bound
   localparam int NODE_COUNT = 1 << ADDR_BITS;
   localparam int CNT_BITS   = 11;                      // leaf_count register
   localparam int VALUE_BITS = 32;
   localparam int SUM_BITS   = 42;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CNT_BITS-1:0] LEAVES_MAX = CNT_BITS'(1 << LEAF_BITS);
   localparam logic [CNT_BITS-1:0] CNT_RESET  = CNT_BITS'(1024);
   localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;

   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_DEC   = 2'd1;
   localparam logic [1:0] CMD_INC   = 2'd2;
   localparam logic [1:0] CMD_QUERY = 2'd3;

   typedef struct packed {
      logic [1:0]            cmd;
      logic [LEAF_BITS-1:0]  first_index;
      logic [LEAF_BITS-1:0]  last_index;
      logic [VALUE_BITS-1:0] amount;
   } req_type;

   typedef struct packed {
      logic [SUM_BITS-1:0] answer;
      logic                empty_range;
   } rsp_type;

   typedef enum logic [2:0] {
      K_LOAD  = 3'd0,
      K_DEC   = 3'd1,
      K_INC   = 3'd2,
      K_QUERY = 3'd3,
      K_EMPTY = 3'd4
   } kind_type;

   // classified operation handed from front to back
   typedef struct packed {
      kind_type              kind;
      logic [POS_BITS-1:0]   lo;      // leaf node address, or range start
      logic [POS_BITS-1:0]   hi;      // range end, exclusive (queries only)
      logic [VALUE_BITS-1:0] amount;
   } op_type;

   typedef struct packed {
      logic [SUM_BITS-1:0]   sum;
      logic [VALUE_BITS-1:0] min;
   } node_type;

endpackage
`default_nettype wire

FILE: rtl/segment_tree_sum_min_point_update.sv
// Top level of the segment tree sum/min block: front, queue and back.
// Depends on stsm_pkg, stsm_front, stsm_queue, stsm_back.
//
//   channel  ports                            direction  moves
//   req      req_valid/req_stall/req_payload  in         one command transaction
//   rsp      rsp_valid/rsp_stall/rsp_payload  out        one query answer
//   csr      csr_write_enable/csr_write_data  in         leaf count write
//
// Steps: an update writes the leaf, then for each tree level reads the sibling
// and writes the parent; a query reads its left and right bound nodes per level,
// moves both bounds up a level and at the end writes the result register.
// The node memory gives one read per cycle beside its separate write port.
// Reset and every leaf count write start a clearing sweep over all nodes of
// the node memory; req_stall is high meanwhile.
// A two-entry queue lets the front take transactions while the back works;
// a waiting result sits in the output register while the next item runs.
`default_nettype none
module segment_tree_sum_min_point_update (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  stsm_pkg::req_type            req_payload,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output stsm_pkg::rsp_type            rsp_payload,
   input  wire                          csr_write_enable,
   input  wire [stsm_pkg::CNT_BITS-1:0] csr_write_data
);
   logic             push, pop, full, not_empty, clearing;
   stsm_pkg::op_type push_op, head_op;

   // classify and drop out-of-range updates
   stsm_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .queue_full       (full),
      .back_clearing    (clearing),
      .push             (push),
      .push_op          (push_op)
   );

   stsm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_op   (push_op),
      .pop       (pop),
      .full      (full),
      .not_empty (not_empty),
      .head_op   (head_op)
   );

   // tree walk, memory and result register
   stsm_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .not_empty        (not_empty),
      .head_op          (head_op),
      .pop              (pop),
      .clearing         (clearing),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload)
   );
endmodule
`default_nettype wire

FILE: rtl/stsm_front.sv
// Front end: leaf count register, transaction accept and classification.
// Depends on stsm_pkg.
`default_nettype none
module stsm_front (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  stsm_pkg::req_type            req_payload,
   input  wire                          csr_write_enable,
   input  wire [stsm_pkg::CNT_BITS-1:0] csr_write_data,
   input  wire                          queue_full,
   input  wire                          back_clearing,
   output logic                         push,
   output stsm_pkg::op_type             push_op
);
   logic [stsm_pkg::CNT_BITS-1:0] leaf_count_ff, leaf_count_in;
   logic [stsm_pkg::CNT_BITS-1:0] n_eff;
   logic [stsm_pkg::LEAF_BITS-1:0] last_clip;
   logic [stsm_pkg::LEAF_BITS-1:0] n_less;
   logic fi_out, empty;

   always_comb begin
      leaf_count_in = csr_write_enable ? csr_write_data : leaf_count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         leaf_count_ff <= stsm_pkg::CNT_RESET;
      end else begin
         leaf_count_ff <= leaf_count_in;
      end
   end

   always_comb begin
      if (leaf_count_ff == '0) begin
         n_eff = stsm_pkg::CNT_BITS'(1);
      end else if (leaf_count_ff > stsm_pkg::LEAVES_MAX) begin
         n_eff = stsm_pkg::LEAVES_MAX;
      end else begin
         n_eff = leaf_count_ff;
      end
      n_less    = stsm_pkg::LEAF_BITS'(n_eff - stsm_pkg::CNT_BITS'(1));
      last_clip = (req_payload.last_index > n_less) ? n_less : req_payload.last_index;
      fi_out    = {1'b0, req_payload.first_index} >= n_eff;
      empty     = fi_out || (req_payload.first_index > last_clip);

      req_stall = queue_full || back_clearing || csr_write_enable;

      push_op.amount = req_payload.amount;
      push_op.lo = stsm_pkg::POS_BITS'(req_payload.first_index)
                 + stsm_pkg::POS_BITS'(1 << stsm_pkg::LEAF_BITS);
      push_op.hi = stsm_pkg::POS_BITS'(last_clip)
                 + stsm_pkg::POS_BITS'((1 << stsm_pkg::LEAF_BITS) + 1);
      unique case (req_payload.cmd)
         stsm_pkg::CMD_LOAD:  push_op.kind = stsm_pkg::K_LOAD;
         stsm_pkg::CMD_DEC:   push_op.kind = stsm_pkg::K_DEC;
         stsm_pkg::CMD_INC:   push_op.kind = stsm_pkg::K_INC;
         default:             push_op.kind = empty ? stsm_pkg::K_EMPTY : stsm_pkg::K_QUERY;
      endcase
      // updates to a leaf past the count are dropped here
      push = req_valid && !req_stall
          && ((req_payload.cmd == stsm_pkg::CMD_QUERY) || !fi_out);
   end
endmodule
`default_nettype wire

FILE: rtl/stsm_queue.sv
// Short queue of classified operations between front and back.
// Depends on stsm_pkg.
`default_nettype none
module stsm_queue (
   input  wire               clock,
   input  wire               reset,
   input  wire               push,
   input  stsm_pkg::op_type  push_op,
   input  wire               pop,
   output logic              full,
   output logic              not_empty,
   output stsm_pkg::op_type  head_op
);
   stsm_pkg::op_type slot_ff [stsm_pkg::QUEUE_DEPTH];
   logic rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      full      = count_ff == 2'(stsm_pkg::QUEUE_DEPTH);
      not_empty = count_ff != 2'd0;
      head_op   = slot_ff[rd_ptr_ff];
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end
endmodule
`default_nettype wire

FILE: rtl/stsm_back.sv
// Back end: node memory, clearing sweep, leaf-to-root update walk,
// bottom-up range query and the result register. Depends on stsm_pkg.
`default_nettype none
module stsm_back (
   input  wire               clock,
   input  wire               reset,
   input  wire               csr_write_enable,
   input  wire               not_empty,
   input  stsm_pkg::op_type  head_op,
   output logic              pop,
   output logic              clearing,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output stsm_pkg::rsp_type rsp_payload
);
   typedef enum logic [8:0] {
      S_CLR    = 9'b000000001,
      S_IDLE   = 9'b000000010,
      S_U_LEAF = 9'b000000100,
      S_U_SIB  = 9'b000001000,
      S_U_PAR  = 9'b000010000,
      S_Q_L    = 9'b000100000,
      S_Q_R    = 9'b001000000,
      S_Q_UP   = 9'b010000000,
      S_OUT    = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   stsm_pkg::node_type mem [stsm_pkg::NODE_COUNT];
   stsm_pkg::node_type rd_ff, wr_data;
   logic [stsm_pkg::ADDR_BITS-1:0] rd_addr, wr_addr;
   logic wr_en;

   logic [stsm_pkg::ADDR_BITS-1:0] clr_ff, clr_in;
   stsm_pkg::op_type op_ff, op_in;
   logic [stsm_pkg::POS_BITS-1:0] l_ff, l_in, r_ff, r_in;
   logic [stsm_pkg::SUM_BITS-1:0] sum_ff, sum_in;
   logic [stsm_pkg::VALUE_BITS-1:0] min_ff, min_in;
   logic pend_ff, pend_in;
   logic rsp_valid_ff, rsp_valid_in;
   stsm_pkg::rsp_type rsp_ff, rsp_in;

   logic [stsm_pkg::VALUE_BITS-1:0] old_v, new_v;
   logic [stsm_pkg::VALUE_BITS:0] inc_sum;
   logic [stsm_pkg::ADDR_BITS-1:0] node, parent;
   logic [stsm_pkg::POS_BITS-1:0] l_half, r_half;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      op_in        = op_ff;
      l_in         = l_ff;
      r_in         = r_ff;
      sum_in       = sum_ff;
      min_in       = min_ff;
      pend_in      = 1'b0;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      wr_en        = 1'b0;
      wr_addr      = clr_ff;
      wr_data      = '0;
      rd_addr      = head_op.lo[stsm_pkg::ADDR_BITS-1:0];
      pop          = 1'b0;

      node    = l_ff[stsm_pkg::ADDR_BITS-1:0];
      parent  = node >> 1;
      old_v   = rd_ff.min;
      inc_sum = {1'b0, old_v} + {1'b0, op_ff.amount};
      l_half  = l_ff >> 1;
      r_half  = r_ff >> 1;
      unique case (op_ff.kind)
         stsm_pkg::K_LOAD: new_v = op_ff.amount;
         stsm_pkg::K_DEC:  new_v = (op_ff.amount >= old_v) ? '0 : old_v - op_ff.amount;
         stsm_pkg::K_INC:  new_v = inc_sum[stsm_pkg::VALUE_BITS]
                                   ? stsm_pkg::VALUE_MAX
                                   : inc_sum[stsm_pkg::VALUE_BITS-1:0];
         default:          new_v = old_v;
      endcase

      unique case (state_ff)
         S_CLR: begin
            wr_en  = 1'b1;
            clr_in = clr_ff + stsm_pkg::ADDR_BITS'(1);
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (not_empty) begin
               pop    = 1'b1;
               op_in  = head_op;
               l_in   = head_op.lo;
               r_in   = head_op.hi;
               sum_in = '0;
               min_in = stsm_pkg::VALUE_MAX;
               unique case (head_op.kind)
                  stsm_pkg::K_EMPTY: state_in = S_OUT;
                  stsm_pkg::K_QUERY: state_in = S_Q_L;
                  default:           state_in = S_U_LEAF;
               endcase
            end
         end
         S_U_LEAF: begin
            wr_en    = 1'b1;
            wr_addr  = node;
            wr_data  = '{sum: stsm_pkg::SUM_BITS'(new_v), min: new_v};
            sum_in   = stsm_pkg::SUM_BITS'(new_v);
            min_in   = new_v;
            state_in = S_U_SIB;
         end
         S_U_SIB: begin
            rd_addr  = node ^ stsm_pkg::ADDR_BITS'(1);
            state_in = S_U_PAR;
         end
         S_U_PAR: begin
            sum_in   = sum_ff + rd_ff.sum;
            min_in   = (rd_ff.min < min_ff) ? rd_ff.min : min_ff;
            wr_en    = 1'b1;
            wr_addr  = parent;
            wr_data  = '{sum: sum_in, min: min_in};
            l_in     = stsm_pkg::POS_BITS'(parent);
            state_in = (parent == stsm_pkg::ADDR_BITS'(1)) ? S_IDLE : S_U_SIB;
         end
         S_Q_L: begin
            rd_addr = node;
            if (l_ff[0]) begin
               pend_in = 1'b1;
               l_in    = l_ff + stsm_pkg::POS_BITS'(1);
            end
            state_in = S_Q_R;
         end
         S_Q_R: begin
            if (pend_ff) begin
               sum_in = sum_ff + rd_ff.sum;
               min_in = (rd_ff.min < min_ff) ? rd_ff.min : min_ff;
            end
            rd_addr = stsm_pkg::ADDR_BITS'(r_ff - stsm_pkg::POS_BITS'(1));
            if (r_ff[0]) begin
               pend_in = 1'b1;
               r_in    = r_ff - stsm_pkg::POS_BITS'(1);
            end
            state_in = S_Q_UP;
         end
         S_Q_UP: begin
            if (pend_ff) begin
               sum_in = sum_ff + rd_ff.sum;
               min_in = (rd_ff.min < min_ff) ? rd_ff.min : min_ff;
            end
            l_in     = l_half;
            r_in     = r_half;
            state_in = (l_half < r_half) ? S_Q_L : S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               if (op_ff.kind == stsm_pkg::K_EMPTY) begin
                  rsp_in = '{answer: '0, empty_range: 1'b1};
               end else begin
                  rsp_in = '{answer: sum_ff - stsm_pkg::SUM_BITS'(min_ff),
                             empty_range: 1'b0};
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_CLR;
      endcase

      if (csr_write_enable) begin
         state_in = S_CLR;
         clr_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      l_ff   <= l_in;
      r_ff   <= r_in;
      sum_ff <= sum_in;
      min_ff <= min_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   assign clearing    = state_ff == S_CLR;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
endmodule
`default_nettype wire

FILE: tb/segment_tree_sum_min_point_update_test.sv
// Testbench for segment_tree_sum_min_point_update: drives command transactions,
// predicts query answers from a flat leaf array and checks every answer in order.
// Depends on stsm_pkg and the RTL under rtl/.
`timescale 1ns / 1ps
module segment_tree_sum_min_point_update_test;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   stsm_pkg::req_type             req_payload = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   stsm_pkg::rsp_type             rsp_payload;
   logic                          csr_write_enable = 1'b0;
   logic [stsm_pkg::CNT_BITS-1:0] csr_write_data = '0;

   segment_tree_sum_min_point_update dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   always #1 clock = ~clock;

   // Shadow of the block: leaf values and the effective leaf count.
   // Sum and min over leaves equal what the tree nodes would give.
   logic [stsm_pkg::VALUE_BITS-1:0] leaf_shadow [0:(1<<stsm_pkg::LEAF_BITS)-1];
   int                              live_leaves = 1024;

   stsm_pkg::req_type pending_cmds[$];
   stsm_pkg::rsp_type pending_answers[$];

   int  mismatches = 0;
   int  answers_seen = 0;
   int  empties_seen = 0;
   int  cmds_sent = 0;
   int  phases_run = 0;
   bit  quiet = 1'b0;          // no idling on either side
   int  hold_left = 0;         // long receiver hold-off, in cycles
   int  gap_left = 0;
   int  stall_left = 0;
   bit  next_valid;
   bit  next_stall;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("MISMATCH %s: got %0h expected %0h (answer %0d)", what, got, want,
               answers_seen);
      mismatches++;
   endtask

   task automatic clear_shadow(input logic [stsm_pkg::CNT_BITS-1:0] count);
      foreach (leaf_shadow[i]) leaf_shadow[i] = '0;
      if (count == 0) live_leaves = 1;
      else if (count > stsm_pkg::LEAVES_MAX) live_leaves = int'(stsm_pkg::LEAVES_MAX);
      else live_leaves = int'(count);
   endtask

   // Apply one accepted transaction to the shadow; queries queue an answer.
   task automatic predict_command(input stsm_pkg::req_type c);
      logic [stsm_pkg::VALUE_BITS-1:0] v;
      logic [stsm_pkg::SUM_BITS-1:0]   span_sum;
      logic [stsm_pkg::VALUE_BITS-1:0] span_min;
      int                              span_end;
      stsm_pkg::rsp_type               r;
      if (c.cmd == stsm_pkg::CMD_QUERY) begin
         span_end = (c.last_index > live_leaves - 1) ? live_leaves - 1 : c.last_index;
         r = '0;
         if (c.first_index >= live_leaves || c.first_index > span_end) begin
            r.empty_range = 1'b1;
         end else begin
            span_sum = '0;
            span_min = stsm_pkg::VALUE_MAX;
            for (int i = c.first_index; i <= span_end; i++) begin
               span_sum += stsm_pkg::SUM_BITS'(leaf_shadow[i]);
               if (leaf_shadow[i] < span_min) span_min = leaf_shadow[i];
            end
            r.answer = span_sum - stsm_pkg::SUM_BITS'(span_min);
         end
         pending_answers.push_back(r);
      end else if (c.first_index < live_leaves) begin
         v = leaf_shadow[c.first_index];
         case (c.cmd)
            stsm_pkg::CMD_LOAD: begin
               v = c.amount;
            end
            stsm_pkg::CMD_DEC: begin
               v = (c.amount >= v) ? '0 : v - c.amount;
            end
            default: begin
               v = (stsm_pkg::VALUE_MAX - v < c.amount) ? stsm_pkg::VALUE_MAX
                                                        : v + c.amount;
            end
         endcase
         leaf_shadow[c.first_index] = v;
      end
   endtask

   // Driver: offers the queued commands, with random idle bursts.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_command(req_payload);
            void'(pending_cmds.pop_front());
            cmds_sent++;
         end
         next_valid = 1'b0;
         if (req_valid && req_stall) begin
            next_valid = 1'b1;            // hold the stalled transaction
         end else if (gap_left > 0) begin
            gap_left--;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            gap_left = $urandom_range(1, 18);
         end else if (pending_cmds.size() > 0) begin
            next_valid = 1'b1;
         end
         req_valid <= next_valid;
         if (next_valid) req_payload <= pending_cmds[0];
      end
   end

   // Monitor: random stall bursts plus the long hold-off, checks answers.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            answers_seen++;
            if (pending_answers.size() == 0) begin
               report_mismatch("unexpected answer", 64'(rsp_payload), 64'(0));
            end else begin
               if (rsp_payload.answer !== pending_answers[0].answer)
                  report_mismatch("answer", 64'(rsp_payload.answer),
                                  64'(pending_answers[0].answer));
               if (rsp_payload.empty_range !== pending_answers[0].empty_range)
                  report_mismatch("empty_range", 64'(rsp_payload.empty_range),
                                  64'(pending_answers[0].empty_range));
               if (pending_answers[0].empty_range) empties_seen++;
               void'(pending_answers.pop_front());
            end
         end
         if (stall_left > 0) stall_left--;
         else if (!quiet && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 18);
         next_stall = (hold_left > 0) || (stall_left > 0);
         rsp_stall <= next_stall;
      end
   end

   // Long hold-off counter, armed once from the stimulus.
   always @(posedge clock) begin
      if (hold_left > 0) hold_left <= hold_left - 1;
   end

   task automatic push_cmd(input logic [1:0] cmd, input int first, input int last,
                           input logic [stsm_pkg::VALUE_BITS-1:0] amount);
      stsm_pkg::req_type c;
      c.cmd = cmd;
      c.first_index = stsm_pkg::LEAF_BITS'(first);
      c.last_index = stsm_pkg::LEAF_BITS'(last);
      c.amount = amount;
      pending_cmds.push_back(c);
   endtask

   function automatic logic [stsm_pkg::VALUE_BITS-1:0] pick_amount();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return stsm_pkg::VALUE_MAX;
         2: return $urandom_range(0, 255);
         3: return stsm_pkg::VALUE_MAX - $urandom_range(0, 255);
         default: return $urandom;
      endcase
   endfunction

   // Mostly in-range indexes, a few past the live leaves and some anywhere.
   function automatic int pick_index();
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, (1 << stsm_pkg::LEAF_BITS) - 1);
         1: return live_leaves - 1 + $urandom_range(0, 3);
         default: return $urandom_range(0, live_leaves - 1);
      endcase
   endfunction

   task automatic push_random(input int count);
      int first;
      int last;
      repeat (count) begin
         first = pick_index();
         last = ($urandom_range(0, 3) == 0) ? pick_index()
                                            : first + $urandom_range(0, live_leaves);
         if (last > (1 << stsm_pkg::LEAF_BITS) - 1) last = (1 << stsm_pkg::LEAF_BITS) - 1;
         push_cmd(2'($urandom_range(0, 3)), first, last, pick_amount());
      end
   endtask

   // Wait until nothing is in flight, then let a possible trailing update finish.
   task automatic wait_drained();
      while (pending_cmds.size() > 0 || req_valid || pending_answers.size() > 0)
         @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_leaf_count(input int count);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data <= stsm_pkg::CNT_BITS'(count);
      @(posedge clock);
      clear_shadow(stsm_pkg::CNT_BITS'(count));
      csr_write_enable <= 1'b0;
      phases_run++;
   endtask

   initial begin
      clear_shadow(stsm_pkg::CNT_RESET);
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: eight leaves, saturation, floor, ignored updates, empty spans.
      write_leaf_count(8);
      push_cmd(stsm_pkg::CMD_LOAD, 0, 0, stsm_pkg::VALUE_MAX);
      push_cmd(stsm_pkg::CMD_LOAD, 7, 0, stsm_pkg::VALUE_MAX);
      push_cmd(stsm_pkg::CMD_INC, 0, 0, 5);
      push_cmd(stsm_pkg::CMD_QUERY, 0, 1023, 0);
      push_cmd(stsm_pkg::CMD_DEC, 7, 0, 32'h1234);
      push_cmd(stsm_pkg::CMD_DEC, 3, 0, 10);
      push_cmd(stsm_pkg::CMD_LOAD, 8, 0, 99);
      push_cmd(stsm_pkg::CMD_INC, 1023, 0, 7);
      push_cmd(stsm_pkg::CMD_LOAD, 2, 0, 42);
      push_cmd(stsm_pkg::CMD_INC, 5, 0, stsm_pkg::VALUE_MAX);
      push_cmd(stsm_pkg::CMD_QUERY, 0, 7, 0);
      push_cmd(stsm_pkg::CMD_QUERY, 5, 2, 0);
      push_cmd(stsm_pkg::CMD_QUERY, 8, 9, 0);
      push_cmd(stsm_pkg::CMD_QUERY, 1023, 1023, 0);
      push_cmd(stsm_pkg::CMD_QUERY, 3, 3, 0);
      push_cmd(stsm_pkg::CMD_DEC, 0, 0, stsm_pkg::VALUE_MAX);
      push_cmd(stsm_pkg::CMD_QUERY, 0, 1, 0);
      push_cmd(stsm_pkg::CMD_LOAD, 6, 1023, 1);
      push_cmd(stsm_pkg::CMD_QUERY, 6, 7, 0);

      write_leaf_count(1024);
      push_random(150);
      write_leaf_count(0);            // acts as one leaf
      push_random(30);
      write_leaf_count(2047);         // clamps to the maximum
      push_random(150);
      write_leaf_count(1);
      push_random(20);

      // Long receiver hold-off while the sender keeps offering; the start of the
      // hold-off overlaps the clearing sweep, the rest fills the block.
      write_leaf_count(37);
      push_random(150);
      hold_left <= 2600;

      // Final part without idling.
      write_leaf_count(1000);
      quiet = 1'b1;
      push_random(60);

      wait_drained();
      repeat (100) @(posedge clock);
      $display("Covered %0d commands over %0d leaf count settings, %0d answers (%0d empty).",
               cmds_sent, phases_run, answers_seen, empties_seen);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Timeout with %0d commands and %0d answers outstanding",
               pending_cmds.size(), pending_answers.size());
      $display("Some tests failed");
      $finish;
   end

endmodule

FILE: sim.f
rtl/stsm_pkg.sv
rtl/stsm_front.sv
rtl/stsm_queue.sv
rtl/stsm_back.sv
rtl/segment_tree_sum_min_point_update.sv
tb/segment_tree_sum_min_point_update_test.sv
